// ----- design/bbd_pkg.sv -----
package bbd_pkg;

	localparam int SZ_W    = 13;
	localparam int STEP_W  = 29;
	localparam int PIX_W   = 32;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;
	localparam int NUM_CFG = 6;

	localparam logic [SZ_W-1:0]   SIZE_RESET = 13'd1;
	localparam logic [STEP_W-1:0] STEP_RESET = 29'd65536;
	localparam logic [2:0]        MAX_RES    = 3'd4;

	typedef enum logic [2:0] {
		REG_SRC_W,
		REG_SRC_H,
		REG_DST_W,
		REG_DST_H,
		REG_X_STEP,
		REG_Y_STEP
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_POS,
		ST_HMUL,
		ST_VMUL,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic capture;
		logic rd;
		logic pos_ld;
		logic hmul;
		logic vmul;
		logic push;
		logic push_last;
		logic fin;
	} ctrl_cmd_t;

	typedef struct packed {
		logic busy_restart;
		logic cand_ok;
		logic out_free;
	} dp_sts_t;

endpackage

// ----- design/bbd_if.sv -----
interface bbd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] chan0;
	logic [7:0] chan1;
	logic [7:0] chan2;
	logic [7:0] chan3;

	modport source(output valid, output chan0, output chan1, output chan2, output chan3,
		input ready);
	modport sink(input valid, input chan0, input chan1, input chan2, input chan3,
		output ready);
endinterface

interface bbd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] res0;
	logic [7:0] res1;
	logic [7:0] res2;
	logic [7:0] res3;
	logic       row_end;
	logic       frame_end;
	logic       run_last;

	modport source(output valid, output res0, output res1, output res2, output res3,
		output row_end, output frame_end, output run_last, input ready);
	modport sink(input valid, input res0, input res1, input res2, input res3,
		input row_end, input frame_end, input run_last, output ready);
endinterface

// ----- design/bilinear_bgra_downscaler_core.sv -----
// Each accepted pixel passes capture, line read and position; it ends in the finish state.
// A result passes position, horizontal and vertical multiply, and is pushed into the output
// register from the position state once the output is free; these steps set the per-result cost.
// A configuration write to a valid register blocks input while the frame counters restart.
// Reset clears control state and loads default registers; the line buffer is not cleared.
module bilinear_bgra_downscaler_core #(
	parameter int MAX_WIDTH = 4096,
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bbd_pkg::ADDR_W-1:0]  paddr,
	input  logic [bbd_pkg::DATA_W-1:0]  pwdata,
	output logic [bbd_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	bbd_in_if.sink                      in_ch,
	bbd_out_if.source                   out_ch
);

	bbd_pkg::ctrl_cmd_t cmd;
	bbd_pkg::dp_sts_t   sts;

	assign pready = 1'b1;

	bbd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	bbd_datapath #(
		.MAX_WIDTH(MAX_WIDTH),
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.chan0    (in_ch.chan0),
		.chan1    (in_ch.chan1),
		.chan2    (in_ch.chan2),
		.chan3    (in_ch.chan3),
		.out_ready(out_ch.ready),
		.out_valid(out_ch.valid),
		.res0     (out_ch.res0),
		.res1     (out_ch.res1),
		.res2     (out_ch.res2),
		.res3     (out_ch.res3),
		.row_end  (out_ch.row_end),
		.frame_end(out_ch.frame_end),
		.run_last (out_ch.run_last)
	);

endmodule

// ----- design/bbd_ram.sv -----
module bbd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/bbd_ctrl.sv -----
module bbd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bbd_pkg::dp_sts_t    sts,
	output bbd_pkg::ctrl_cmd_t  cmd
);

	bbd_pkg::state_t state_q, state_d;
	logic [2:0] n_q;
	logic       pend_q;
	logic       go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bbd_pkg::ST_IDLE;
			n_q     <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.fin) begin
				n_q <= '0;
			end else if (cmd.vmul) begin
				n_q <= n_q + 3'd1;
			end
			if (cmd.vmul) begin
				pend_q <= 1'b1;
			end else if (cmd.push) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		go       = sts.cand_ok && (n_q < bbd_pkg::MAX_RES);
		unique case (state_q)
			bbd_pkg::ST_IDLE: begin
				in_ready = !sts.busy_restart;
				if (in_valid && !sts.busy_restart) begin
					cmd.capture = 1'b1;
					state_d     = bbd_pkg::ST_READ;
				end
			end
			bbd_pkg::ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = bbd_pkg::ST_POS;
			end
			bbd_pkg::ST_POS: begin
				// A finished result waits here until the output is free; go then tells whether another follows.
				if (!pend_q || sts.out_free) begin
					cmd.push      = pend_q;
					cmd.push_last = !go;
					if (go) begin
						cmd.pos_ld = 1'b1;
						state_d    = bbd_pkg::ST_HMUL;
					end else begin
						state_d = bbd_pkg::ST_FIN;
					end
				end
			end
			bbd_pkg::ST_HMUL: begin
				cmd.hmul = 1'b1;
				state_d  = bbd_pkg::ST_VMUL;
			end
			bbd_pkg::ST_VMUL: begin
				cmd.vmul = 1'b1;
				state_d  = bbd_pkg::ST_POS;
			end
			bbd_pkg::ST_FIN: begin
				cmd.fin = 1'b1;
				state_d = bbd_pkg::ST_IDLE;
			end
			default: begin
				state_d = bbd_pkg::ST_IDLE;
			end
		endcase
	end

	a_read_then_pos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bbd_pkg::ST_READ |=> state_q == bbd_pkg::ST_POS)
		else $error("line read not followed by position stage");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bbd_pkg::ST_POS && pend_q && !sts.out_free) |=>
		(state_q == bbd_pkg::ST_POS && pend_q))
		else $error("pending result lost while output was full");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bbd_pkg::ST_VMUL |=> n_q == $past(n_q) + 3'd1)
		else $error("result count did not advance");

endmodule

// ----- design/bbd_datapath.sv -----
module bbd_datapath #(
	parameter int MAX_WIDTH = 4096,
	parameter int FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bbd_pkg::ctrl_cmd_t             cmd,
	output bbd_pkg::dp_sts_t               sts,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bbd_pkg::ADDR_W-1:0]     paddr,
	input  logic [bbd_pkg::DATA_W-1:0]     pwdata,
	output logic [bbd_pkg::DATA_W-1:0]     prdata,
	input  logic [7:0]                     chan0,
	input  logic [7:0]                     chan1,
	input  logic [7:0]                     chan2,
	input  logic [7:0]                     chan3,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [7:0]                     res0,
	output logic [7:0]                     res1,
	output logic [7:0]                     res2,
	output logic [7:0]                     res3,
	output logic                           row_end,
	output logic                           frame_end,
	output logic                           run_last
);

	localparam int CW     = $clog2(MAX_WIDTH);
	localparam int EW     = (CW + 1 > bbd_pkg::SZ_W) ? CW + 1 : bbd_pkg::SZ_W;
	localparam int ACC_A  = CW + bbd_pkg::STEP_W + 2;
	localparam int ACC_B  = EW + FRAC_BITS + 1;
	localparam int ACC_W  = (ACC_A > ACC_B) ? ACC_A : ACC_B;
	localparam int POS_W  = CW + FRAC_BITS;
	localparam int WF     = FRAC_BITS + 1;
	localparam int TOP_W  = 8 + FRAC_BITS;
	localparam int SUM_W  = 8 + 2 * FRAC_BITS;

	localparam logic [bbd_pkg::STEP_W-1:0] ONE_S = bbd_pkg::STEP_W'(1) << FRAC_BITS;
	localparam logic [ACC_W-1:0]           ONE_A = ACC_W'(1) << FRAC_BITS;
	localparam logic [WF-1:0]              ONE_W = WF'(1) << FRAC_BITS;
	localparam logic [EW-1:0]              MAXW  = EW'(MAX_WIDTH);

	// Configuration registers.
	logic [bbd_pkg::SZ_W-1:0]   src_w_q, src_h_q, dst_w_q, dst_h_q;
	logic [bbd_pkg::STEP_W-1:0] x_step_q, y_step_q;
	logic                       restart_q;
	logic                       wr, idx_ok;
	bbd_pkg::reg_idx_t          idx;

	// Effective sizes and steps.
	logic [EW-1:0]              sw_x, sh_x, dw_x, dh_x;
	logic [EW-1:0]              sw_e, sh_e, dw_e, dh_e;
	logic [bbd_pkg::STEP_W-1:0] xs_e, ys_e;

	// Scan state.
	logic [CW-1:0]    src_col_q, src_row_q, dst_col_q;
	logic [CW:0]      dst_row_q;
	logic [ACC_W-1:0] acc_x_q, acc_y_q;
	logic [31:0]      cur_q, left_q, al_q, up;
	logic             col_wrap, row_wrap, do_restart, dcol_wrap;

	// Position of the candidate destination pixel.
	logic [ACC_W-1:0]     lim_x, lim_y, px_raw, py_raw, px_full, py_full;
	logic [POS_W-1:0]     px, py;
	logic [FRAC_BITS-1:0] fx, fy;
	logic [CW:0]          tx, ty, r_x, c_x;
	logic [31:0]          tl, tr, bl, br;

	// Arithmetic stages.
	logic [31:0]          tl_s1, tr_s1, bl_s1, br_s1;
	logic [FRAC_BITS-1:0] fx_s1, fy_s1, fy_s2;
	logic                 re_s1, fe_s1, re_s2, fe_s2, re_s3, fe_s3;
	logic [WF-1:0]        wx0, wx1, wy0, wy1;
	logic [TOP_W-1:0]     top_c [4];
	logic [TOP_W-1:0]     bot_c [4];
	logic [TOP_W-1:0]     top_s2 [4];
	logic [TOP_W-1:0]     bot_s2 [4];
	logic [SUM_W-1:0]     sum_c [4];
	logic [7:0]           v_s3 [4];
	logic [7:0]           res_q [4];
	logic                 out_valid_q, row_end_q, frame_end_q, run_last_q;

	assign wr     = psel && penable && pwrite;
	assign idx    = bbd_pkg::reg_idx_t'(paddr[4:2]);
	assign idx_ok = paddr[4:2] < 3'(bbd_pkg::NUM_CFG);

	always_comb begin
		unique case (idx)
			bbd_pkg::REG_SRC_W:  prdata = bbd_pkg::DATA_W'(src_w_q);
			bbd_pkg::REG_SRC_H:  prdata = bbd_pkg::DATA_W'(src_h_q);
			bbd_pkg::REG_DST_W:  prdata = bbd_pkg::DATA_W'(dst_w_q);
			bbd_pkg::REG_DST_H:  prdata = bbd_pkg::DATA_W'(dst_h_q);
			bbd_pkg::REG_X_STEP: prdata = bbd_pkg::DATA_W'(x_step_q);
			bbd_pkg::REG_Y_STEP: prdata = bbd_pkg::DATA_W'(y_step_q);
			default:             prdata = '0;
		endcase
	end

	always_comb begin
		sw_x = EW'(src_w_q);
		sh_x = EW'(src_h_q);
		dw_x = EW'(dst_w_q);
		dh_x = EW'(dst_h_q);
		sw_e = (sw_x == '0) ? EW'(1) : ((sw_x > MAXW) ? MAXW : sw_x);
		sh_e = (sh_x == '0) ? EW'(1) : ((sh_x > MAXW) ? MAXW : sh_x);
		dw_e = (dw_x == '0) ? EW'(1) : ((dw_x > sw_e) ? sw_e : dw_x);
		dh_e = (dh_x == '0) ? EW'(1) : ((dh_x > sh_e) ? sh_e : dh_x);
		xs_e = (x_step_q < ONE_S) ? ONE_S : x_step_q;
		ys_e = (y_step_q < ONE_S) ? ONE_S : y_step_q;
	end

	// The accumulators hold (2d+1)*step; the position is half of that less one half, clamped to the last source pixel.
	always_comb begin
		lim_x   = ACC_W'(sw_e - EW'(1)) << FRAC_BITS;
		lim_y   = ACC_W'(sh_e - EW'(1)) << FRAC_BITS;
		px_raw  = (acc_x_q - ONE_A) >> 1;
		py_raw  = (acc_y_q - ONE_A) >> 1;
		px_full = (px_raw > lim_x) ? lim_x : px_raw;
		py_full = (py_raw > lim_y) ? lim_y : py_raw;
		px      = POS_W'(px_full);
		py      = POS_W'(py_full);
		fx      = px[FRAC_BITS-1:0];
		fy      = py[FRAC_BITS-1:0];
		tx      = {1'b0, px[POS_W-1:FRAC_BITS]} + (CW + 1)'(fx != '0);
		ty      = {1'b0, py[POS_W-1:FRAC_BITS]} + (CW + 1)'(fy != '0);
		r_x     = {1'b0, src_row_q};
		c_x     = {1'b0, src_col_q};
		bl      = (fx != '0) ? left_q : cur_q;
		br      = cur_q;
		tl      = (fy != '0) ? ((fx != '0) ? al_q : up) : bl;
		tr      = (fy != '0) ? up : br;
	end

	assign sts.busy_restart = restart_q;
	assign sts.cand_ok      = (EW'(dst_row_q) < dh_e) &&
		!((ty > r_x) || ((ty == r_x) && (tx > c_x)));
	assign sts.out_free     = !out_valid_q || out_ready;

	assign col_wrap   = (EW'(src_col_q) + EW'(1)) >= sw_e;
	assign row_wrap   = (EW'(src_row_q) + EW'(1)) >= sh_e;
	assign dcol_wrap  = (EW'(dst_col_q) + EW'(1)) >= dw_e;
	assign do_restart = restart_q || (cmd.fin && col_wrap && row_wrap);

	bbd_ram #(
		.WIDTH(bbd_pkg::PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_line (
		.clk  (clk),
		.we   (cmd.fin),
		.waddr(src_col_q),
		.wdata(cur_q),
		.re   (cmd.rd),
		.raddr(src_col_q),
		.rdata(up)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q     <= bbd_pkg::SIZE_RESET;
			src_h_q     <= bbd_pkg::SIZE_RESET;
			dst_w_q     <= bbd_pkg::SIZE_RESET;
			dst_h_q     <= bbd_pkg::SIZE_RESET;
			x_step_q    <= bbd_pkg::STEP_RESET;
			y_step_q    <= bbd_pkg::STEP_RESET;
			restart_q   <= 1'b1;
			src_col_q   <= '0;
			src_row_q   <= '0;
			dst_col_q   <= '0;
			dst_row_q   <= '0;
			acc_x_q     <= '0;
			acc_y_q     <= '0;
			left_q      <= '0;
			al_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			restart_q <= wr && idx_ok;
			if (wr) begin
				case (idx)
					bbd_pkg::REG_SRC_W:  src_w_q  <= pwdata[bbd_pkg::SZ_W-1:0];
					bbd_pkg::REG_SRC_H:  src_h_q  <= pwdata[bbd_pkg::SZ_W-1:0];
					bbd_pkg::REG_DST_W:  dst_w_q  <= pwdata[bbd_pkg::SZ_W-1:0];
					bbd_pkg::REG_DST_H:  dst_h_q  <= pwdata[bbd_pkg::SZ_W-1:0];
					bbd_pkg::REG_X_STEP: x_step_q <= pwdata[bbd_pkg::STEP_W-1:0];
					bbd_pkg::REG_Y_STEP: y_step_q <= pwdata[bbd_pkg::STEP_W-1:0];
					default: ;
				endcase
			end

			if (do_restart) begin
				src_col_q <= '0;
				src_row_q <= '0;
				dst_col_q <= '0;
				dst_row_q <= '0;
				acc_x_q   <= ACC_W'(xs_e);
				acc_y_q   <= ACC_W'(ys_e);
			end else if (cmd.pos_ld) begin
				if (dcol_wrap) begin
					dst_col_q <= '0;
					dst_row_q <= dst_row_q + (CW + 1)'(1);
					acc_x_q   <= ACC_W'(xs_e);
					acc_y_q   <= acc_y_q + (ACC_W'(ys_e) << 1);
				end else begin
					dst_col_q <= dst_col_q + CW'(1);
					acc_x_q   <= acc_x_q + (ACC_W'(xs_e) << 1);
				end
			end else if (cmd.fin) begin
				if (col_wrap) begin
					src_col_q <= '0;
					src_row_q <= src_row_q + CW'(1);
				end else begin
					src_col_q <= src_col_q + CW'(1);
				end
			end

			if (cmd.fin) begin
				left_q <= cur_q;
				al_q   <= up;
			end

			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		wx1 = {1'b0, fx_s1};
		wx0 = ONE_W - wx1;
		wy1 = {1'b0, fy_s2};
		wy0 = ONE_W - wy1;
		for (int k = 0; k < 4; k++) begin
			top_c[k] = TOP_W'(tl_s1[8*k +: 8]) * TOP_W'(wx0) +
				TOP_W'(tr_s1[8*k +: 8]) * TOP_W'(wx1);
			bot_c[k] = TOP_W'(bl_s1[8*k +: 8]) * TOP_W'(wx0) +
				TOP_W'(br_s1[8*k +: 8]) * TOP_W'(wx1);
			sum_c[k] = SUM_W'(top_s2[k]) * SUM_W'(wy0) + SUM_W'(bot_s2[k]) * SUM_W'(wy1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cur_q <= {chan3, chan2, chan1, chan0};
		end
		if (cmd.pos_ld) begin
			tl_s1 <= tl;
			tr_s1 <= tr;
			bl_s1 <= bl;
			br_s1 <= br;
			fx_s1 <= fx;
			fy_s1 <= fy;
			re_s1 <= dcol_wrap;
			fe_s1 <= dcol_wrap && ((EW'(dst_row_q) + EW'(1)) == dh_e);
		end
		if (cmd.hmul) begin
			for (int k = 0; k < 4; k++) begin
				top_s2[k] <= top_c[k];
				bot_s2[k] <= bot_c[k];
			end
			fy_s2 <= fy_s1;
			re_s2 <= re_s1;
			fe_s2 <= fe_s1;
		end
		if (cmd.vmul) begin
			for (int k = 0; k < 4; k++) begin
				v_s3[k] <= sum_c[k][SUM_W-1:2*FRAC_BITS];
			end
			re_s3 <= re_s2;
			fe_s3 <= fe_s2;
		end
		if (cmd.push) begin
			for (int k = 0; k < 4; k++) begin
				res_q[k] <= v_s3[k];
			end
			row_end_q   <= re_s3;
			frame_end_q <= fe_s3;
			run_last_q  <= cmd.push_last;
		end
	end

	assign out_valid = out_valid_q;
	assign res0      = res_q[0];
	assign res1      = res_q[1];
	assign res2      = res_q[2];
	assign res3      = res_q[3];
	assign row_end   = row_end_q;
	assign frame_end = frame_end_q;
	assign run_last  = run_last_q;

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		restart_q |=> (src_col_q == '0 && src_row_q == '0 && dst_row_q == '0))
		else $error("frame counters not cleared by restart");

	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (!out_valid_q || out_ready))
		else $error("result pushed over an untaken result");

	a_frame_end_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && frame_end_q |-> row_end_q)
		else $error("frame end without row end");

endmodule
